// ----- rtl/core/dlr_pkg.sv -----
package dlr_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF   = 2;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;
  localparam logic [12:0] HEIGHT_MAX   = 13'd4096;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_DIV
  } back_state_t;

  // classified command passed from front to back
  typedef struct packed {
    logic               op;
    logic signed [13:0] dx;
    logic signed [13:0] dy;
    logic signed [12:0] bx;
    logic [11:0]        by;
    logic [31:0]        color;
  } cmd_t;

  typedef struct packed {
    logic signed [12:0] x;
    logic [11:0]        y;
    logic [31:0]        color;
    logic               last;
  } pixel_t;

endpackage

// ----- rtl/core/dlr_queue.sv -----
module dlr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = dlr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- rtl/core/dlr_front.sv -----
module dlr_front (
  input  logic               op,
  input  logic signed [12:0] begin_x,
  input  logic signed [12:0] begin_y,
  input  logic signed [12:0] end_x,
  input  logic signed [12:0] end_y,
  input  logic [31:0]        color,
  input  logic [12:0]        height,
  output dlr_pkg::cmd_t      cmd
);

  logic [12:0] rows;
  logic [12:0] max_row;
  logic [11:0] by_c;
  logic [11:0] ey_c;

  function automatic logic [11:0] clamp_row(input logic signed [12:0] y,
                                            input logic [12:0] top);
    logic [11:0] r;
    if (y[12]) begin
      r = '0;
    end else if ($unsigned(y) > top) begin
      r = top[11:0];
    end else begin
      r = y[11:0];
    end
    return r;
  endfunction

  always_comb begin
    if (height == '0) begin
      rows = 13'd1;
    end else if (height > dlr_pkg::HEIGHT_MAX) begin
      rows = dlr_pkg::HEIGHT_MAX;
    end else begin
      rows = height;
    end
  end

  assign max_row = rows - 13'd1;
  assign by_c    = clamp_row(begin_y, max_row);
  assign ey_c    = clamp_row(end_y, max_row);

  always_comb begin
    cmd.op    = op;
    cmd.dx    = {end_x[12], end_x} - {begin_x[12], begin_x};
    cmd.dy    = $signed({2'b00, ey_c}) - $signed({2'b00, by_c});
    cmd.bx    = begin_x;
    cmd.by    = by_c;
    cmd.color = color;
  end

endmodule

// ----- rtl/core/dlr_back.sv -----
module dlr_back #(
  parameter int FRACTION_BITS = dlr_pkg::FRACTION_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  dlr_pkg::cmd_t   cmd,
  input  logic            cmd_empty,
  output logic            cmd_pop,
  output dlr_pkg::pixel_t pix,
  output logic            pix_push,
  input  logic            pix_full
);

  localparam int DW = 14 + FRACTION_BITS;
  localparam int PW = 15 + FRACTION_BITS;
  localparam int SW = FRACTION_BITS + 2;
  localparam int CW = $clog2(DW + 1);
  localparam logic [CW-1:0] DIV_LAST = CW'(DW - 1);

  dlr_pkg::back_state_t state, state_next;

  logic signed [PW-1:0] pos_x, pos_y;
  logic signed [SW-1:0] step_x, step_y;
  logic [13:0]          left;
  logic [31:0]          color;
  logic signed [13:0]   dx, dy;
  logic [26:0]          sqx, sqy;
  logic [26:0]          rad, root, bitv;
  logic [13:0]          len;
  logic [CW-1:0]        cnt;
  logic [DW-1:0]        dvd_x, dvd_y;
  logic [14:0]          rem_x, rem_y;

  logic                 is_load;
  logic                 has_pix;
  logic signed [27:0]   prod_x, prod_y;
  logic [26:0]          trial;
  logic                 root_ge;
  logic [26:0]          rad_next, root_next;
  logic [14:0]          rs_x, rs_y;
  logic                 ge_x, ge_y;
  logic [14:0]          rem_x_next, rem_y_next;
  logic [DW-1:0]        dvd_x_next, dvd_y_next;
  logic [SW-1:0]        q_x, q_y;
  logic [13:0]          mag_x, mag_y;
  logic                 neg_px, neg_py;
  logic [PW-1:0]        abs_px, abs_py, sh_px, sh_py;

  assign is_load = (cmd.op == dlr_pkg::OP_LOAD);
  assign has_pix = (left != '0);

  assign prod_x = dx * dx;
  assign prod_y = dy * dy;

  // one digit pair of the integer square root
  assign trial     = root + bitv;
  assign root_ge   = (rad >= trial);
  assign rad_next  = root_ge ? rad - trial : rad;
  assign root_next = root_ge ? (root >> 1) + bitv : root >> 1;

  // one bit of each restoring division; quotient shifts into the dividend
  assign rs_x       = {rem_x[13:0], dvd_x[DW-1]};
  assign rs_y       = {rem_y[13:0], dvd_y[DW-1]};
  assign ge_x       = (rs_x >= {1'b0, len});
  assign ge_y       = (rs_y >= {1'b0, len});
  assign rem_x_next = ge_x ? rs_x - {1'b0, len} : rs_x;
  assign rem_y_next = ge_y ? rs_y - {1'b0, len} : rs_y;
  assign dvd_x_next = {dvd_x[DW-2:0], ge_x};
  assign dvd_y_next = {dvd_y[DW-2:0], ge_y};
  assign q_x        = {1'b0, dvd_x_next[FRACTION_BITS:0]};
  assign q_y        = {1'b0, dvd_y_next[FRACTION_BITS:0]};

  assign mag_x = dx[13] ? -dx : dx;
  assign mag_y = dy[13] ? -dy : dy;

  // pixel coordinates truncate toward zero
  assign neg_px = pos_x[PW-1];
  assign neg_py = pos_y[PW-1];
  assign abs_px = neg_px ? -pos_x : pos_x;
  assign abs_py = neg_py ? -pos_y : pos_y;
  assign sh_px  = abs_px >> FRACTION_BITS;
  assign sh_py  = abs_py >> FRACTION_BITS;

  always_comb begin
    pix.x     = neg_px ? -sh_px[12:0] : sh_px[12:0];
    pix.y     = neg_py ? -sh_py[11:0] : sh_py[11:0];
    pix.color = color;
    pix.last  = (left == 14'd1);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dlr_pkg::ST_IDLE: begin
        if (!cmd_empty && is_load) begin
          state_next = dlr_pkg::ST_SQUARE;
        end
      end
      dlr_pkg::ST_SQUARE: state_next = dlr_pkg::ST_SUM;
      dlr_pkg::ST_SUM:    state_next = dlr_pkg::ST_ROOT;
      dlr_pkg::ST_ROOT: begin
        if (bitv[0]) begin
          state_next = (root_next == '0) ? dlr_pkg::ST_IDLE : dlr_pkg::ST_DIV;
        end
      end
      dlr_pkg::ST_DIV: begin
        if (cnt == DIV_LAST) begin
          state_next = dlr_pkg::ST_IDLE;
        end
      end
      default: state_next = dlr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = 1'b0;
    pix_push = 1'b0;
    if (state == dlr_pkg::ST_IDLE && !cmd_empty) begin
      // drop a step with nothing left; hold a step while the output is full
      cmd_pop  = is_load || !has_pix || !pix_full;
      pix_push = !is_load && has_pix && !pix_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dlr_pkg::ST_IDLE;
      left  <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        dlr_pkg::ST_IDLE: begin
          if (cmd_pop && is_load) begin
            dx    <= cmd.dx;
            dy    <= cmd.dy;
            color <= cmd.color;
            pos_x <= {{2{cmd.bx[12]}}, cmd.bx, {FRACTION_BITS{1'b0}}};
            pos_y <= {3'b000, cmd.by, {FRACTION_BITS{1'b0}}};
            left  <= '0;
          end else if (pix_push) begin
            pos_x <= pos_x + {{(PW-SW){step_x[SW-1]}}, step_x};
            pos_y <= pos_y + {{(PW-SW){step_y[SW-1]}}, step_y};
            left  <= left - 14'd1;
          end
        end
        dlr_pkg::ST_SQUARE: begin
          sqx <= prod_x[26:0];
          sqy <= prod_y[26:0];
        end
        dlr_pkg::ST_SUM: begin
          rad  <= sqx + sqy;
          root <= '0;
          bitv <= {1'b1, 26'd0};
        end
        dlr_pkg::ST_ROOT: begin
          rad  <= rad_next;
          root <= root_next;
          bitv <= bitv >> 2;
          if (bitv[0]) begin
            len   <= root_next[13:0];
            left  <= root_next[13:0];
            cnt   <= '0;
            rem_x <= '0;
            rem_y <= '0;
            dvd_x <= {mag_x, {FRACTION_BITS{1'b0}}};
            dvd_y <= {mag_y, {FRACTION_BITS{1'b0}}};
          end
        end
        dlr_pkg::ST_DIV: begin
          rem_x <= rem_x_next;
          rem_y <= rem_y_next;
          dvd_x <= dvd_x_next;
          dvd_y <= dvd_y_next;
          cnt   <= cnt + CW'(1);
          if (cnt == DIV_LAST) begin
            step_x <= dx[13] ? -q_x : q_x;
            step_y <= dy[13] ? -q_y : q_y;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/dda_line_rasterizer_top.sv -----
// Load: popped, then the back end squares, sums, runs 14 square-root digit steps
//   and divides for both axes, one quotient bit per cycle.
// Step: via both queues; one pixel per cycle when idle and the result queue has room.
// A zero-length load finishes after the square root and emits no pixels.
// Reset (synchronous, rst high) empties both queues, clears the line, height to 480.
module dda_line_rasterizer_top #(
  parameter int FRACTION_BITS = dlr_pkg::FRACTION_BITS_DEF,
  parameter int QUEUE_DEPTH   = dlr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               op,
  input  logic signed [12:0] begin_x,
  input  logic signed [12:0] begin_y,
  input  logic signed [12:0] end_x,
  input  logic signed [12:0] end_y,
  input  logic [31:0]        color,
  output logic               empty,
  input  logic               pop,
  output logic signed [12:0] pixel_x,
  output logic [11:0]        pixel_y,
  output logic [31:0]        pixel_color,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [12:0]        cfg_data
);

  logic [12:0]     height;
  dlr_pkg::cmd_t   cmd_in, cmd_out;
  logic            cmd_empty, cmd_pop;
  dlr_pkg::pixel_t pix_in, pix_out;
  logic            pix_push, pix_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      height <= dlr_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      height <= cfg_data;
    end
  end

  dlr_front u_front (
    .op      (op),
    .begin_x (begin_x),
    .begin_y (begin_y),
    .end_x   (end_x),
    .end_y   (end_y),
    .color   (color),
    .height  (height),
    .cmd     (cmd_in)
  );

  dlr_queue #(
    .WIDTH ($bits(dlr_pkg::cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (cmd_in),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  dlr_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .pix       (pix_in),
    .pix_push  (pix_push),
    .pix_full  (pix_full)
  );

  dlr_queue #(
    .WIDTH ($bits(dlr_pkg::pixel_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_pix_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (pix_push),
    .wr_data (pix_in),
    .full    (pix_full),
    .rd_en   (pop),
    .rd_data (pix_out),
    .empty   (empty)
  );

  assign pixel_x     = pix_out.x;
  assign pixel_y     = pix_out.y;
  assign pixel_color = pix_out.color;
  assign last        = pix_out.last;

endmodule

// ----- rtl/core/dlr_checker.sv -----
module dlr_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [12:0] pixel_x,
  input logic [11:0] pixel_y,
  input logic [31:0] pixel_color,
  input logic        last,
  input logic        cfg_ready
);

  // reset leaves both queues empty
  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  // hold a waiting result until its transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(pixel_x) && $stable(pixel_y)
                       && $stable(pixel_color) && $stable(last))
    else $error("waiting result changed");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration channel stalled");

endmodule

bind dda_line_rasterizer_top dlr_checker u_dlr_checker (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .pixel_x     (pixel_x),
  .pixel_y     (pixel_y),
  .pixel_color (pixel_color),
  .last        (last),
  .cfg_ready   (cfg_ready)
);
